// ===== hw/rtl/rgb_to_hsv_converter_assert.svh =====
// Assertion macros shared by the rgb_to_hsv_converter RTL.
// Each macro expects signals clk and rst_n in the including scope.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RGBHSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RGBHSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rgbhsv_pkg.sv =====
// Types and constants for the RGB to HSV converter.
// No dependencies; used by every module of the block by scoped names.
package rgbhsv_pkg;

  localparam int unsigned ChanW = 8;   // channel width
  localparam int unsigned HueW  = 15;  // hue, degrees in Q9.6
  localparam int unsigned QuoW  = 12;  // quotient bits, one per divider cell
  localparam int unsigned DivW  = 8;   // divisor / remainder width
  localparam int unsigned NumW  = QuoW + DivW;

  localparam logic [HueW-1:0] HueGreen = 15'd7680;   // 120 degrees
  localparam logic [HueW-1:0] HueBlue  = 15'd15360;  // 240 degrees
  localparam logic [HueW-1:0] HueFull  = 15'd23040;  // 360 degrees

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
    logic             hue_undefined;
  } hsv_t;

  // Pixel facts carried alongside the division.
  typedef struct packed {
    sector_t          sector;
    logic             hue_neg;     // hue difference below zero
    logic             grey;        // delta zero
    logic             black;       // max zero
    logic [ChanW-1:0] brightness;
  } side_t;

  // One restoring-division lane: remainder, dividend bits still to shift in,
  // quotient bits so far, divisor.
  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [QuoW-1:0] num;
    logic [QuoW-1:0] quo;
    logic [DivW-1:0] dvs;
  } lane_t;

  typedef struct packed {
    lane_t hue;
    lane_t sat;
    side_t side;
  } div_word_t;

endpackage

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// RGB to HSV converter, top level. Depends on rgbhsv_pkg, rgbhsv_prep,
// rgbhsv_div_cell, rgbhsv_post and rgb_to_hsv_converter_assert.svh.
//
// Usage:
//   in_word  (red, green, blue, 8 bits each) enters on in_valid/in_ready.
//   out_word (hue Q9.6 degrees, saturation, brightness, hue_undefined)
//   leaves on out_valid/out_ready. Each word in gives exactly one word out,
//   in order.
// Stages: 1 front stage, 12 divider cells and 1 output register, each
//   registered, between acceptance and out_valid.
// Throughput: one word per clock. Every stage has its own valid bit, so a
//   word can be accepted each cycle while the pipe flows.
// Stall: when out_ready is low, the output register holds; bubbles ahead of
//   it are squeezed out, and in_ready drops only once every stage is full.
// Reset: rst_n (synchronous, active low) empties the pipe; no clearing pass.
// Rate is set by the chain of 12 division cells, each retiring one quotient
//   bit of both the hue and the saturation divide per word per cycle while the pipe flows.
module rgb_to_hsv_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rgbhsv_pkg::pix_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output rgbhsv_pkg::hsv_t  out_word
);

`include "rgb_to_hsv_converter_assert.svh"

  localparam int unsigned NumCells = rgbhsv_pkg::QuoW;

  // stage links: index 0 is the front stage output, NumCells the last cell's
  rgbhsv_pkg::div_word_t link_word  [NumCells+1];
  logic                  link_valid [NumCells+1];
  logic                  link_ready [NumCells+1];

  rgbhsv_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_valid),
    .i_ready (in_ready),
    .i_word  (in_word),
    .o_valid (link_valid[0]),
    .o_ready (link_ready[0]),
    .o_word  (link_word[0])
  );

  // divider chain: one quotient bit per cell, MSB first
  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
    rgbhsv_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (link_valid[gi]),
      .i_ready (link_ready[gi]),
      .i_word  (link_word[gi]),
      .o_valid (link_valid[gi+1]),
      .o_ready (link_ready[gi+1]),
      .o_word  (link_word[gi+1])
    );
  end

  rgbhsv_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (link_valid[NumCells]),
    .i_ready (link_ready[NumCells]),
    .i_word  (link_word[NumCells]),
    .o_valid (out_valid),
    .o_ready (out_ready),
    .o_word  (out_word)
  );

  // black pixel: flag set, everything else zero
  `RGBHSV_ASSERT_NOW(a_black_zero, out_valid && out_word.hue_undefined,
    (out_word.hue == '0) && (out_word.saturation == '0) && (out_word.brightness == '0),
    "black pixel result not all zero")

  // flag exactly when brightness is zero
  `RGBHSV_ASSERT_NOW(a_flag_match, out_valid,
    out_word.hue_undefined == (out_word.brightness == '0),
    "hue_undefined disagrees with brightness")

  // hue stays below a full turn
  `RGBHSV_ASSERT_NOW(a_hue_range, out_valid, out_word.hue < rgbhsv_pkg::HueFull,
    "hue out of range")

  // last cell's hue quotient never exceeds 60 degrees; grey divides by zero
  `RGBHSV_ASSERT_NOW(a_quo_range, link_valid[NumCells] && !link_word[NumCells].side.grey,
    link_word[NumCells].hue.quo <= 12'd3840, "hue quotient above 3840")

  // saturation quotient fits eight bits
  `RGBHSV_ASSERT_NOW(a_sat_range, link_valid[NumCells] && !link_word[NumCells].side.black,
    link_word[NumCells].sat.quo[rgbhsv_pkg::QuoW-1:rgbhsv_pkg::ChanW] == '0,
    "saturation quotient overflow")

endmodule

// ===== hw/rtl/rgbhsv_prep.sv =====
// Front stage: max/min, sector, difference and scaled dividends.
// Depends on rgbhsv_pkg.
module rgbhsv_prep (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   i_valid,
  output logic                   i_ready,
  input  rgbhsv_pkg::pix_t       i_word,
  output logic                   o_valid,
  input  logic                   o_ready,
  output rgbhsv_pkg::div_word_t  o_word
);

  logic                  valid_r;
  logic                  valid_nxt;
  rgbhsv_pkg::div_word_t word_r;
  rgbhsv_pkg::div_word_t word_nxt;

  logic [7:0]  mx, mn, delta, op_a, op_b, mag;
  logic        neg;
  rgbhsv_pkg::sector_t sector;
  logic [rgbhsv_pkg::NumW-1:0] hue_num, sat_num;

  assign i_ready = !valid_r || o_ready;

  always_comb begin
    mx = i_word.red;
    if (i_word.green > mx) mx = i_word.green;
    if (i_word.blue > mx)  mx = i_word.blue;
    mn = i_word.red;
    if (i_word.green < mn) mn = i_word.green;
    if (i_word.blue < mn)  mn = i_word.blue;
    delta = mx - mn;

    // ties: red over green over blue
    if (i_word.red == mx) begin
      sector = rgbhsv_pkg::SEC_RED;
      op_a   = i_word.green;
      op_b   = i_word.blue;
    end else if (i_word.green == mx) begin
      sector = rgbhsv_pkg::SEC_GREEN;
      op_a   = i_word.blue;
      op_b   = i_word.red;
    end else begin
      sector = rgbhsv_pkg::SEC_BLUE;
      op_a   = i_word.red;
      op_b   = i_word.green;
    end
    neg = op_a < op_b;
    mag = neg ? (op_b - op_a) : (op_a - op_b);

    // |diff| * 3840 = |diff| * 4096 - |diff| * 256
    hue_num = {mag, 12'd0} - {4'd0, mag, 8'd0};
    // delta * 255 = delta * 256 - delta
    sat_num = {4'd0, ({delta, 8'd0} - {8'd0, delta})};

    word_nxt.hue.rem = hue_num[rgbhsv_pkg::NumW-1:rgbhsv_pkg::QuoW];
    word_nxt.hue.num = hue_num[rgbhsv_pkg::QuoW-1:0];
    word_nxt.hue.quo = '0;
    word_nxt.hue.dvs = delta;
    word_nxt.sat.rem = sat_num[rgbhsv_pkg::NumW-1:rgbhsv_pkg::QuoW];
    word_nxt.sat.num = sat_num[rgbhsv_pkg::QuoW-1:0];
    word_nxt.sat.quo = '0;
    word_nxt.sat.dvs = mx;
    word_nxt.side.sector     = sector;
    word_nxt.side.hue_neg    = neg;
    word_nxt.side.grey       = (delta == 8'd0);
    word_nxt.side.black      = (mx == 8'd0);
    word_nxt.side.brightness = mx;

    valid_nxt = i_ready ? i_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      word_r <= word_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_word  = word_r;

endmodule

// ===== hw/rtl/rgbhsv_div_cell.sv =====
// One restoring-division cell: one quotient bit for the hue and the
// saturation lanes, registered. Depends on rgbhsv_pkg.
module rgbhsv_div_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   i_valid,
  output logic                   i_ready,
  input  rgbhsv_pkg::div_word_t  i_word,
  output logic                   o_valid,
  input  logic                   o_ready,
  output rgbhsv_pkg::div_word_t  o_word
);

  logic                  valid_r;
  logic                  valid_nxt;
  rgbhsv_pkg::div_word_t word_r;
  rgbhsv_pkg::div_word_t word_nxt;

  function automatic rgbhsv_pkg::lane_t div_step(input rgbhsv_pkg::lane_t ln);
    rgbhsv_pkg::lane_t       res;
    logic [rgbhsv_pkg::DivW:0] part;
    logic [rgbhsv_pkg::DivW:0] diff;
    logic                      take;
    part = {ln.rem, ln.num[rgbhsv_pkg::QuoW-1]};
    diff = part - {1'b0, ln.dvs};
    take = (part >= {1'b0, ln.dvs});
    // rem < dvs holds, so part < 2*dvs and the difference fits DivW bits
    res.rem = take ? diff[rgbhsv_pkg::DivW-1:0] : part[rgbhsv_pkg::DivW-1:0];
    res.num = {ln.num[rgbhsv_pkg::QuoW-2:0], 1'b0};
    res.quo = {ln.quo[rgbhsv_pkg::QuoW-2:0], take};
    res.dvs = ln.dvs;
    return res;
  endfunction

  assign i_ready = !valid_r || o_ready;

  always_comb begin
    word_nxt.hue  = div_step(i_word.hue);
    word_nxt.sat  = div_step(i_word.sat);
    word_nxt.side = i_word.side;
    valid_nxt     = i_ready ? i_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      word_r <= word_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_word  = word_r;

endmodule

// ===== hw/rtl/rgbhsv_post.sv =====
// Back stage: sector offset, sign, wrap and special cases into the output
// register. Depends on rgbhsv_pkg.
module rgbhsv_post (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   i_valid,
  output logic                   i_ready,
  input  rgbhsv_pkg::div_word_t  i_word,
  output logic                   o_valid,
  input  logic                   o_ready,
  output rgbhsv_pkg::hsv_t       o_word
);

  logic             valid_r;
  logic             valid_nxt;
  rgbhsv_pkg::hsv_t word_r;
  rgbhsv_pkg::hsv_t word_nxt;

  logic [rgbhsv_pkg::HueW-1:0] base;
  logic [rgbhsv_pkg::HueW:0]   hsum;
  logic [rgbhsv_pkg::HueW:0]   hwrap;
  logic [rgbhsv_pkg::HueW:0]   q_ext;

  assign i_ready = !valid_r || o_ready;

  always_comb begin
    unique case (i_word.side.sector)
      rgbhsv_pkg::SEC_RED:   base = '0;
      rgbhsv_pkg::SEC_GREEN: base = rgbhsv_pkg::HueGreen;
      rgbhsv_pkg::SEC_BLUE:  base = rgbhsv_pkg::HueBlue;
      default:               base = '0;
    endcase
    q_ext = {{(rgbhsv_pkg::HueW + 1 - rgbhsv_pkg::QuoW){1'b0}}, i_word.hue.quo};
    hsum  = i_word.side.hue_neg ? ({1'b0, base} - q_ext) : ({1'b0, base} + q_ext);
    // top bit set means negative: wrap by a full turn
    hwrap = hsum[rgbhsv_pkg::HueW] ? (hsum + {1'b0, rgbhsv_pkg::HueFull}) : hsum;

    word_nxt.hue = (i_word.side.grey || i_word.side.black) ? '0
                                                           : hwrap[rgbhsv_pkg::HueW-1:0];
    word_nxt.saturation = i_word.side.black ? '0
                                            : i_word.sat.quo[rgbhsv_pkg::ChanW-1:0];
    word_nxt.brightness    = i_word.side.brightness;
    word_nxt.hue_undefined = i_word.side.black;

    valid_nxt = i_ready ? i_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      word_r <= word_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_word  = word_r;

endmodule

// ===== dv/rgb_to_hsv_converter_tb.sv =====
// Self-checking testbench for rgb_to_hsv_converter: pixel words in, HSV words out.
// Depends on rgbhsv_pkg (pix_t, hsv_t, sector_t, hue constants) and the block's RTL.
module rgb_to_hsv_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // 60 degrees in Q9.6, the scale applied to diff/delta inside a sector
  localparam int HUE_SIXTY    = 3840;
  localparam int RANDOM_WORDS = 600;
  // cycles with no word moving on either side before the run is called hung
  localparam int STALL_LIMIT  = 2000;
  // receiver hold-off, long enough to fill all 14 stages and back up the input
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AT      = 150;
  // stretch of words with no idling on either side
  localparam int CALM_FIRST   = 300;
  localparam int CALM_LAST    = 440;
  localparam int DRAIN_CYCLES = 30;

  // Expected-HSV store: predicts each accepted pixel and checks outputs in order.
  class hsv_scoreboard;
    rgbhsv_pkg::hsv_t expected_q[$];
    int               errors;

    function rgbhsv_pkg::hsv_t predict_hsv(rgbhsv_pkg::pix_t p);
      int                  r, g, b, top, low, spread, diff, base, quo, h;
      rgbhsv_pkg::sector_t sec;
      rgbhsv_pkg::hsv_t    res;
      r = p.red;
      g = p.green;
      b = p.blue;
      top = r;
      low = r;
      if (g > top) top = g;
      if (b > top) top = b;
      if (g < low) low = g;
      if (b < low) low = b;
      spread = top - low;
      res = '0;
      res.brightness = top[7:0];
      if (top == 0) begin
        // black: hue has no meaning, flag it instead
        res.hue_undefined = 1'b1;
      end else begin
        res.saturation = 8'((spread * 255) / top);
        if (spread != 0) begin
          // ties go to red, then green
          if (r == top) sec = rgbhsv_pkg::SEC_RED;
          else if (g == top) sec = rgbhsv_pkg::SEC_GREEN;
          else sec = rgbhsv_pkg::SEC_BLUE;
          case (sec)
            rgbhsv_pkg::SEC_RED: begin
              diff = g - b;
              base = 0;
            end
            rgbhsv_pkg::SEC_GREEN: begin
              diff = b - r;
              base = int'(rgbhsv_pkg::HueGreen);
            end
            default: begin
              diff = r - g;
              base = int'(rgbhsv_pkg::HueBlue);
            end
          endcase
          // magnitude divided first, so the quotient truncates toward zero
          quo = ((diff < 0 ? -diff : diff) * HUE_SIXTY) / spread;
          h = (diff < 0) ? base - quo : base + quo;
          if (h < 0) h += int'(rgbhsv_pkg::HueFull);
          res.hue = h[rgbhsv_pkg::HueW-1:0];
        end
      end
      return res;
    endfunction

    function void note_pixel(rgbhsv_pkg::pix_t p);
      expected_q.push_back(predict_hsv(p));
    endfunction

    function void check_result(rgbhsv_pkg::hsv_t got);
      rgbhsv_pkg::hsv_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.hue !== want.hue) begin
        errors++;
        $display("%0t: hue mismatch, expected %0d, actual %0d", $time, want.hue, got.hue);
      end
      if (got.saturation !== want.saturation) begin
        errors++;
        $display("%0t: saturation mismatch, expected %0d, actual %0d", $time,
                 want.saturation, got.saturation);
      end
      if (got.brightness !== want.brightness) begin
        errors++;
        $display("%0t: brightness mismatch, expected %0d, actual %0d", $time,
                 want.brightness, got.brightness);
      end
      if (got.hue_undefined !== want.hue_undefined) begin
        errors++;
        $display("%0t: hue_undefined mismatch, expected %0b, actual %0b", $time,
                 want.hue_undefined, got.hue_undefined);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  rgbhsv_pkg::pix_t in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  rgbhsv_pkg::hsv_t out_word;

  hsv_scoreboard hsv_sb;
  int            sent_count = 0;   // input words accepted so far
  int            idle_run   = 0;   // cycles since any word last moved

  rgb_to_hsv_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always #4 clk = ~clk;

  function automatic logic calm_window();
    return sent_count >= CALM_FIRST && sent_count < CALM_LAST;
  endfunction

  // Offer one pixel word, after an occasional random gap outside the calm window;
  // valid stays up until the handshake. Back-to-back words keep in_valid high, so
  // it is never dropped and raised in one step.
  task automatic send_pixel(input rgbhsv_pkg::pix_t p);
    int gap;
    gap = 0;
    if (!calm_window() && $urandom_range(0, 99) < 7) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= p;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  function automatic logic [7:0] corner_value();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Random pixel mix: mostly uniform, with ties for the max, greys,
  // corner values and very dark pixels mixed in.
  function automatic rgbhsv_pkg::pix_t random_pixel();
    rgbhsv_pkg::pix_t p;
    logic [7:0]       top, rest;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    p = rgbhsv_pkg::pix_t'($urandom);
    if (pick < 15) begin
      top  = 8'($urandom_range(1, 255));
      rest = 8'($urandom_range(0, top));
      case ($urandom_range(0, 2))
        0:       p = '{red: top, green: top, blue: rest};
        1:       p = '{red: rest, green: top, blue: top};
        default: p = '{red: top, green: rest, blue: top};
      endcase
    end else if (pick < 25) begin
      top = 8'($urandom);
      p = '{red: top, green: top, blue: top};
    end else if (pick < 35) begin
      p = '{red: corner_value(), green: corner_value(), blue: corner_value()};
    end else if (pick < 40) begin
      p = '{red: 8'($urandom_range(0, 3)), green: 8'($urandom_range(0, 3)),
            blue: 8'($urandom_range(0, 3))};
    end
    return p;
  endfunction

  // Monitor: both handshakes sampled at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) hsv_sb.note_pixel(in_word);
      if (out_valid && out_ready) hsv_sb.check_result(out_word);
    end
  end

  // Watchdog: any cycle without a handshake on either side counts toward a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, none in the calm window, and one long
  // hold-off counted here while the sender keeps offering words.
  initial begin
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm_window()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Sender: reset, directed corner pixels, random stream, then drain and report.
  initial begin
    rgbhsv_pkg::pix_t directed[$];
    hsv_sb = new();
    directed = '{
      '{8'd0,   8'd0,   8'd0},     // black: undefined hue
      '{8'd255, 8'd255, 8'd255},   // white
      '{8'd128, 8'd128, 8'd128},   // mid grey: delta zero
      '{8'd1,   8'd1,   8'd1},     // darkest grey
      '{8'd255, 8'd0,   8'd0},     // pure primaries
      '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255},
      '{8'd255, 8'd255, 8'd0},     // red/green tie: red sector
      '{8'd0,   8'd255, 8'd255},   // green/blue tie: green sector
      '{8'd255, 8'd0,   8'd255},   // red/blue tie: red sector, wraps
      '{8'd255, 8'd0,   8'd1},     // red max, negative diff, wraps near 360
      '{8'd255, 8'd1,   8'd0},
      '{8'd1,   8'd0,   8'd0},     // smallest nonzero max
      '{8'd0,   8'd1,   8'd0},
      '{8'd0,   8'd0,   8'd1},
      '{8'd200, 8'd50,  8'd100},
      '{8'd50,  8'd200, 8'd100},
      '{8'd100, 8'd50,  8'd200},
      '{8'd255, 8'd254, 8'd0},
      '{8'd0,   8'd1,   8'd255},
      '{8'd254, 8'd255, 8'd255},
      '{8'd1,   8'd0,   8'd255},
      '{8'd170, 8'd85,  8'd255}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_pixel(directed[i]);
    for (int i = 0; i < RANDOM_WORDS; i++) send_pixel(random_pixel());
    in_valid <= 1'b0;
    // watchdog bounds this wait if words go missing
    while (hsv_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hsv_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgbhsv_prep.sv
hw/rtl/rgbhsv_div_cell.sv
hw/rtl/rgbhsv_post.sv
hw/rtl/rgb_to_hsv_converter.sv
dv/rgb_to_hsv_converter_tb.sv
